>>> hw/rtl/rens_pkg.sv
package rens_pkg;

  // limits of the schedule
  localparam int unsigned MAX_RANKS  = 256;
  localparam int unsigned MAX_RADIX  = 8;
  localparam int unsigned PHASE_CAP  = 8;

  // field widths
  localparam int unsigned GS_W      = 9;
  localparam int unsigned RADIX_W   = 4;
  localparam int unsigned RANK_W    = 8;
  localparam int unsigned PHASE_W   = 3;
  localparam int unsigned NPH_W     = 4;
  localparam int unsigned NSRC_W    = 3;
  localparam int unsigned DIGIT_W   = 3;

  // shared divider
  localparam int unsigned DIV_W     = 9;
  localparam int unsigned DIVR_W    = 4;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);

  typedef enum logic [1:0] {
    KIND_HDR  = 2'd0,
    KIND_SEND = 2'd1,
    KIND_SRC  = 2'd2,
    KIND_NBR  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    DIV_COLL  = 2'd0,
    DIV_RANK  = 2'd1,
    DIV_TAIL  = 2'd2,
    DIV_DIGIT = 2'd3
  } div_sel_e;

  typedef struct packed {
    logic     load;
    logic     pow_step;
    logic     div_start;
    logic     div_take;
    div_sel_e div_sel;
    logic     dig_init;
    logic     cnt_clr;
    logic     phase_init;
    logic     phase_next;
    logic     nbr_adv;
    logic     emit;
    kind_e    kind;
  } cmd_t;

  typedef struct packed {
    logic pow_more;
    logic div_done;
    logic oor;
    logic sends;
    logic part;
    logic has_src;
    logic l_zero;
    logic ph_last;
    logic src_last;
    logic nbr_is_digit;
    logic nbr_end;
    logic out_free;
  } sts_t;

endpackage

>>> hw/rtl/rens_div.sv
module rens_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [rens_pkg::DIV_W-1:0]   dividend_i,
  input  logic [rens_pkg::DIVR_W-1:0]  divisor_i,
  output logic                         busy_o,
  output logic                         done_o,
  output logic [rens_pkg::DIV_W-1:0]   quotient_o,
  output logic [rens_pkg::DIVR_W-1:0]  remainder_o
);
  import rens_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]     quo_q;
  logic [DIVR_W-1:0]    rem_q;
  logic [DIVR_W-1:0]    dvs_q;

  logic [DIVR_W:0]      trial;
  logic                 ge;
  logic [DIVR_W:0]      diff;
  logic [DIVR_W-1:0]    rem_d;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};
  assign rem_d = ge ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == DIV_CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign busy_o      = busy_q;
  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

>>> hw/rtl/rens_ctrl.sv
module rens_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rens_pkg::sts_t sts_i,
  output rens_pkg::cmd_t cmd_o
);
  import rens_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POW,
    ST_DCOL,
    ST_DRNK,
    ST_DTAIL,
    ST_DIG,
    ST_HDR,
    ST_SEND,
    ST_SRC,
    ST_PINIT,
    ST_NBR
  } state_e;

  state_e state_q, state_d;
  logic   issued_q, issued_d;
  cmd_t   cmd;
  logic   go;

  always_comb begin
    state_d     = state_q;
    cmd         = '0;
    cmd.kind    = KIND_HDR;
    cmd.div_sel = DIV_COLL;
    go          = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.load = 1'b1;
          state_d  = ST_POW;
        end
      end
      ST_POW: begin
        if (sts_i.pow_more) begin
          cmd.pow_step = 1'b1;
        end else begin
          state_d = ST_DCOL;
        end
      end
      ST_DCOL: begin
        cmd.div_sel   = DIV_COLL;
        cmd.div_start = !issued_q;
        if (sts_i.div_done) begin
          cmd.div_take = 1'b1;
          state_d      = ST_DRNK;
        end
      end
      ST_DRNK: begin
        cmd.div_sel   = DIV_RANK;
        cmd.div_start = !issued_q;
        if (sts_i.div_done) begin
          cmd.div_take = 1'b1;
          state_d      = ST_DTAIL;
        end
      end
      ST_DTAIL: begin
        cmd.div_sel   = DIV_TAIL;
        cmd.div_start = !issued_q;
        if (sts_i.div_done) begin
          cmd.div_take = 1'b1;
          if (sts_i.part && !sts_i.l_zero) begin
            cmd.dig_init = 1'b1;
            state_d      = ST_DIG;
          end else begin
            state_d = ST_HDR;
          end
        end
      end
      ST_DIG: begin
        cmd.div_sel   = DIV_DIGIT;
        cmd.div_start = !issued_q;
        if (sts_i.div_done) begin
          cmd.div_take = 1'b1;
          if (sts_i.ph_last) begin
            state_d = ST_HDR;
          end
        end
      end
      ST_HDR: begin
        if (sts_i.out_free) begin
          cmd.emit    = 1'b1;
          cmd.kind    = KIND_HDR;
          cmd.cnt_clr = 1'b1;
          if (sts_i.oor) begin
            state_d = ST_IDLE;
          end else if (sts_i.sends) begin
            state_d = ST_SEND;
          end else if (sts_i.has_src) begin
            state_d = ST_SRC;
          end else if (!sts_i.l_zero) begin
            state_d = ST_PINIT;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_SEND: begin
        if (sts_i.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = KIND_SEND;
          state_d  = ST_IDLE;
        end
      end
      ST_SRC: begin
        if (sts_i.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = KIND_SRC;
          if (sts_i.src_last) begin
            state_d = sts_i.l_zero ? ST_IDLE : ST_PINIT;
          end
        end
      end
      ST_PINIT: begin
        cmd.phase_init = 1'b1;
        state_d        = ST_NBR;
      end
      ST_NBR: begin
        // own digit is skipped without a beat
        if (sts_i.nbr_is_digit) begin
          go = 1'b1;
        end else if (sts_i.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = KIND_NBR;
          go       = 1'b1;
        end
        cmd.nbr_adv = go;
        if (go && sts_i.nbr_end) begin
          if (sts_i.ph_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd.phase_next = 1'b1;
            state_d        = ST_PINIT;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (cmd.div_take) begin
      issued_d = 1'b0;
    end else if (cmd.div_start) begin
      issued_d = 1'b1;
    end else begin
      issued_d = issued_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      issued_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign cmd_o      = cmd;

endmodule

>>> hw/rtl/rens_dp.sv
module rens_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [rens_pkg::GS_W-1:0]      group_size_i,
  input  logic [rens_pkg::RADIX_W-1:0]   radix_i,
  input  logic [rens_pkg::RANK_W-1:0]    query_rank_i,
  input  rens_pkg::cmd_t                 cmd_i,
  output rens_pkg::sts_t                 sts_o,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [1:0]                     kind_o,
  output logic [rens_pkg::PHASE_W-1:0]   phase_o,
  output logic [rens_pkg::RANK_W-1:0]    peer_rank_o,
  output logic [rens_pkg::RADIX_W-1:0]   effective_radix_o,
  output logic [rens_pkg::NPH_W-1:0]     phase_count_o,
  output logic [rens_pkg::GS_W-1:0]      radix_power_o,
  output logic [rens_pkg::GS_W-1:0]      split_point_o,
  output logic [rens_pkg::NSRC_W-1:0]    source_count_o,
  output logic                           participating_o,
  output logic                           last_o
);
  import rens_pkg::*;

  localparam int unsigned PROD_W = GS_W + RADIX_W;
  localparam int unsigned DPROD_W = GS_W + DIGIT_W;

  // working registers
  logic [RANK_W-1:0]  rank_q;
  logic [GS_W-1:0]    n_q;
  logic [RADIX_W-1:0] k_q;
  logic [GS_W-1:0]    p_q;
  logic [NPH_W-1:0]   l_q;
  logic [GS_W-1:0]    coll_q;
  logic [GS_W-1:0]    t_q;
  logic [RANK_W-1:0]  rq_q;
  logic [DIVR_W-1:0]  rr_q;
  logic [DIVR_W-1:0]  tr_q;
  logic [RANK_W-1:0]  cur_q;
  logic [DIGIT_W-1:0] digit_q [PHASE_CAP];
  logic [GS_W-1:0]    pw_q;
  logic [GS_W-1:0]    nbr_q;
  logic [PHASE_W-1:0] ph_q;
  logic [DIVR_W-1:0]  i_q;

  // output register
  logic               out_valid_q;
  kind_e              kind_q;
  logic [PHASE_W-1:0] phase_q;
  logic [RANK_W-1:0]  peer_q;
  logic [RADIX_W-1:0] erad_q;
  logic [NPH_W-1:0]   nph_q;
  logic [GS_W-1:0]    pow_q;
  logic [GS_W-1:0]    split_q;
  logic [NSRC_W-1:0]  nsrc_q;
  logic               part_q;
  logic               last_q;

  logic [GS_W-1:0]    n_sat;
  logic [RADIX_W-1:0] k_sat;
  logic [RADIX_W-1:0] k_eff;

  logic [PROD_W-1:0]  pow_prod;
  logic [RADIX_W-1:0] k_m1;
  logic [GS_W-1:0]    rem_w;

  logic               div_busy, div_done;
  logic [DIV_W-1:0]   div_quo;
  logic [DIVR_W-1:0]  div_rem;
  logic [DIV_W-1:0]   div_dvd;
  logic [DIVR_W-1:0]  div_dvs;

  logic               low, oor, coll_hit, sends, part, tail;
  logic [GS_W-1:0]    sendto_w, send_peer;
  logic [DIVR_W-1:0]  nsrc_w;
  logic [RANK_W-1:0]  newrank_w;
  logic [DIGIT_W-1:0] dig_cur;
  logic [DPROD_W-1:0] dprod;
  logic [GS_W-1:0]    base_w;
  logic [PROD_W-1:0]  nbr_mul;
  logic [PROD_W-1:0]  pw_mul;
  logic [RANK_W-1:0]  real_w;
  logic [RANK_W-1:0]  src_peer;
  logic               ph_last, src_last, nbr_end, nbr_is_digit, l_zero;
  logic               hdr_last, nbr_last, out_free;

  // rec fields of the next beat
  logic [PHASE_W-1:0] rec_phase;
  logic [RANK_W-1:0]  rec_peer;
  logic [RADIX_W-1:0] rec_erad;
  logic [NPH_W-1:0]   rec_nph;
  logic [GS_W-1:0]    rec_pow;
  logic [GS_W-1:0]    rec_split;
  logic [NSRC_W-1:0]  rec_nsrc;
  logic               rec_part;
  logic               rec_last;

  // group size and radix clamps, then the small-group reduction
  always_comb begin
    if (group_size_i == '0) begin
      n_sat = GS_W'(1);
    end else if (group_size_i > GS_W'(MAX_RANKS)) begin
      n_sat = GS_W'(MAX_RANKS);
    end else begin
      n_sat = group_size_i;
    end
    if (radix_i < RADIX_W'(2)) begin
      k_sat = RADIX_W'(2);
    end else if (radix_i > RADIX_W'(MAX_RADIX)) begin
      k_sat = RADIX_W'(MAX_RADIX);
    end else begin
      k_sat = radix_i;
    end
    if (n_sat < GS_W'(k_sat)) begin
      k_eff = (n_sat > GS_W'(2)) ? n_sat[RADIX_W-1:0] : RADIX_W'(2);
    end else begin
      k_eff = k_sat;
    end
  end

  assign pow_prod = PROD_W'(p_q) * PROD_W'(k_q);
  assign k_m1     = k_q - RADIX_W'(1);
  assign rem_w    = n_q - p_q;

  always_comb begin
    case (cmd_i.div_sel)
      DIV_COLL: begin
        div_dvd = rem_w;
        div_dvs = k_m1;
      end
      DIV_RANK: begin
        div_dvd = DIV_W'(rank_q);
        div_dvs = k_q;
      end
      DIV_TAIL: begin
        div_dvd = t_q - GS_W'(1);
        div_dvs = k_q;
      end
      DIV_DIGIT: begin
        div_dvd = DIV_W'(cur_q);
        div_dvs = k_q;
      end
      default: begin
        div_dvd = '0;
        div_dvs = k_q;
      end
    endcase
  end

  rens_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (div_dvd),
    .divisor_i   (div_dvs),
    .busy_o      (div_busy),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // step-1 role of the rank
  assign low      = GS_W'(rank_q) < t_q;
  assign oor      = GS_W'(rank_q) >= n_q;
  assign coll_hit = rr_q == k_m1;
  assign sends    = low && !coll_hit;
  assign part     = !oor && !sends;
  assign sendto_w = GS_W'(rank_q) + GS_W'(k_m1 - rr_q);
  assign send_peer = (sendto_w > t_q - GS_W'(1)) ? t_q : sendto_w;
  // trailing partial group collected by rank t
  assign tail     = (GS_W'(rank_q) == t_q) && (t_q != '0) && (tr_q != k_m1);

  always_comb begin
    if (oor) begin
      nsrc_w = '0;
    end else if (low && coll_hit) begin
      nsrc_w = k_m1;
    end else if (tail) begin
      nsrc_w = tr_q + DIVR_W'(1);
    end else begin
      nsrc_w = '0;
    end
  end

  assign newrank_w = low ? rq_q : RANK_W'(GS_W'(rank_q) - rem_w);

  // base-k digit substitution
  assign dig_cur  = digit_q[ph_q];
  assign dprod    = DPROD_W'(dig_cur) * DPROD_W'(pw_q);
  assign base_w   = GS_W'(newrank_w) - dprod[GS_W-1:0];
  assign nbr_mul  = PROD_W'(nbr_q) * PROD_W'(k_q) + PROD_W'(k_m1);
  assign pw_mul   = PROD_W'(pw_q) * PROD_W'(k_q);
  assign real_w   = (nbr_q < coll_q) ? nbr_mul[RANK_W-1:0] : RANK_W'(nbr_q + rem_w);
  assign src_peer = rank_q - RANK_W'(1) - RANK_W'(i_q);

  assign l_zero       = l_q == '0;
  assign ph_last      = NPH_W'(ph_q) == l_q - NPH_W'(1);
  assign src_last     = i_q == nsrc_w - DIVR_W'(1);
  assign nbr_end      = i_q == k_m1;
  assign nbr_is_digit = i_q == DIVR_W'(dig_cur);
  assign out_free     = !out_valid_q || out_ready_i;
  assign hdr_last     = oor || (!sends && (nsrc_w == '0) && l_zero);
  assign nbr_last     = ph_last && (nbr_end ||
                        ((i_q == k_q - RADIX_W'(2)) && (DIVR_W'(dig_cur) == k_m1)));

  always_comb begin
    sts_o.pow_more     = (pow_prod <= PROD_W'(n_q)) && (l_q < NPH_W'(PHASE_CAP));
    sts_o.div_done     = div_done;
    sts_o.oor          = oor;
    sts_o.sends        = sends;
    sts_o.part         = part;
    sts_o.has_src      = nsrc_w != '0;
    sts_o.l_zero       = l_zero;
    sts_o.ph_last      = ph_last;
    sts_o.src_last     = src_last;
    sts_o.nbr_is_digit = nbr_is_digit;
    sts_o.nbr_end      = nbr_end;
    sts_o.out_free     = out_free;
  end

  always_comb begin
    rec_phase = '0;
    rec_peer  = '0;
    rec_erad  = '0;
    rec_nph   = '0;
    rec_pow   = '0;
    rec_split = '0;
    rec_nsrc  = '0;
    rec_part  = 1'b0;
    rec_last  = 1'b0;
    case (cmd_i.kind)
      KIND_HDR: begin
        rec_erad  = k_q;
        rec_nph   = l_q;
        rec_pow   = p_q;
        rec_split = t_q;
        rec_nsrc  = nsrc_w[NSRC_W-1:0];
        rec_part  = part;
        rec_last  = hdr_last;
      end
      KIND_SEND: begin
        rec_peer = send_peer[RANK_W-1:0];
        rec_last = 1'b1;
      end
      KIND_SRC: begin
        rec_peer = src_peer;
        rec_last = src_last && l_zero;
      end
      KIND_NBR: begin
        rec_phase = ph_q;
        rec_peer  = real_w;
        rec_last  = nbr_last;
      end
      default: begin
        rec_last = 1'b1;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      ph_q        <= '0;
      i_q         <= '0;
    end else begin
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.dig_init || cmd_i.cnt_clr) begin
        ph_q <= '0;
      end else if ((cmd_i.div_take && (cmd_i.div_sel == DIV_DIGIT)) || cmd_i.phase_next) begin
        ph_q <= ph_q + PHASE_W'(1);
      end
      if (cmd_i.cnt_clr || cmd_i.phase_init) begin
        i_q <= '0;
      end else if (cmd_i.nbr_adv || (cmd_i.emit && (cmd_i.kind == KIND_SRC))) begin
        i_q <= i_q + DIVR_W'(1);
      end
    end
  end

  // data registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rank_q <= query_rank_i;
      n_q    <= n_sat;
      k_q    <= k_eff;
      p_q    <= GS_W'(1);
      l_q    <= '0;
    end else if (cmd_i.pow_step) begin
      p_q <= pow_prod[GS_W-1:0];
      l_q <= l_q + NPH_W'(1);
    end
    if (cmd_i.div_take) begin
      case (cmd_i.div_sel)
        DIV_COLL: begin
          coll_q <= div_quo;
          // t = rem*k/(k-1) = rem + rem/(k-1), never above the group size
          t_q    <= rem_w + div_quo;
        end
        DIV_RANK: begin
          rq_q <= div_quo[RANK_W-1:0];
          rr_q <= div_rem;
        end
        DIV_TAIL: begin
          tr_q <= div_rem;
        end
        DIV_DIGIT: begin
          digit_q[ph_q] <= div_rem[DIGIT_W-1:0];
          cur_q         <= div_quo[RANK_W-1:0];
        end
        default: begin
          tr_q <= div_rem;
        end
      endcase
    end
    if (cmd_i.dig_init) begin
      cur_q <= newrank_w;
    end
    if (cmd_i.cnt_clr) begin
      pw_q <= GS_W'(1);
    end else if (cmd_i.phase_next) begin
      pw_q <= pw_mul[GS_W-1:0];
    end
    if (cmd_i.phase_init) begin
      nbr_q <= base_w;
    end else if (cmd_i.nbr_adv) begin
      nbr_q <= nbr_q + pw_q;
    end
    if (cmd_i.emit) begin
      kind_q  <= cmd_i.kind;
      phase_q <= rec_phase;
      peer_q  <= rec_peer;
      erad_q  <= rec_erad;
      nph_q   <= rec_nph;
      pow_q   <= rec_pow;
      split_q <= rec_split;
      nsrc_q  <= rec_nsrc;
      part_q  <= rec_part;
      last_q  <= rec_last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = kind_q;
  assign phase_o           = phase_q;
  assign peer_rank_o       = peer_q;
  assign effective_radix_o = erad_q;
  assign phase_count_o     = nph_q;
  assign radix_power_o     = pow_q;
  assign split_point_o     = split_q;
  assign source_count_o    = nsrc_q;
  assign participating_o   = part_q;
  assign last_o            = last_q;

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> out_free)
    else $error("beat loaded while output register is held");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_div_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_take |-> div_done)
    else $error("divider result taken before done");

  a_nbr_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && (cmd_i.kind == KIND_NBR)) |-> (i_q != DIVR_W'(dig_cur)))
    else $error("neighbor beat equals own digit");

  a_src_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && (cmd_i.kind == KIND_SRC)) |-> (i_q < nsrc_w))
    else $error("source beat beyond source count");

endmodule

>>> hw/rtl/radix_exchange_neighbor_schedule_core.sv
// channel | signals                                         | dir | beat
// in      | in_valid_i, in_ready_o, query_rank_i            | in  | one rank
// out     | out_valid_o, out_ready_i, kind_o .. last_o      | out | one schedule record
// cfg     | psel, penable, pwrite, paddr, pwdata, prdata    | in  | group_size @0, radix @4
//
// a rank runs 3 + D divisions in turn on the shared bit-serial divider, L phases, D = L for a
// rank in step 2 else 0, B beats out
// the next rank is taken once the previous rank's last beat is in the output register
// reset sets group_size to 16 and radix to 2; no memory needs clearing
// out_ready_i low holds the current beat and stalls the sequencer
module radix_exchange_neighbor_schedule_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [rens_pkg::RANK_W-1:0]    query_rank_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     kind_o,
  output logic [rens_pkg::PHASE_W-1:0]   phase_o,
  output logic [rens_pkg::RANK_W-1:0]    peer_rank_o,
  output logic [rens_pkg::RADIX_W-1:0]   effective_radix_o,
  output logic [rens_pkg::NPH_W-1:0]     phase_count_o,
  output logic [rens_pkg::GS_W-1:0]      radix_power_o,
  output logic [rens_pkg::GS_W-1:0]      split_point_o,
  output logic [rens_pkg::NSRC_W-1:0]    source_count_o,
  output logic                           participating_o,
  output logic                           last_o
);
  import rens_pkg::*;

  typedef enum logic {
    REG_GROUP_SIZE = 1'b0,
    REG_RADIX      = 1'b1
  } reg_idx_e;

  logic [GS_W-1:0]    group_size_q;
  logic [RADIX_W-1:0] radix_q;
  reg_idx_e           reg_idx;
  logic               wr_en;
  cmd_t               cmd;
  sts_t               sts;

  assign reg_idx = reg_idx_e'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_size_q <= GS_W'(16);
      radix_q      <= RADIX_W'(2);
    end else if (wr_en) begin
      case (reg_idx)
        REG_GROUP_SIZE: group_size_q <= pwdata[GS_W-1:0];
        REG_RADIX:      radix_q      <= pwdata[RADIX_W-1:0];
        default:        radix_q      <= radix_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GROUP_SIZE: prdata = 32'(group_size_q);
      REG_RADIX:      prdata = 32'(radix_q);
      default:        prdata = '0;
    endcase
  end

  rens_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rens_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .group_size_i      (group_size_q),
    .radix_i           (radix_q),
    .query_rank_i      (query_rank_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .kind_o            (kind_o),
    .phase_o           (phase_o),
    .peer_rank_o       (peer_rank_o),
    .effective_radix_o (effective_radix_o),
    .phase_count_o     (phase_count_o),
    .radix_power_o     (radix_power_o),
    .split_point_o     (split_point_o),
    .source_count_o    (source_count_o),
    .participating_o   (participating_o),
    .last_o            (last_o)
  );

endmodule
